@@ rtl/lbp_pkg.sv @@
// ---------------------------------------------------------------------------
// LBP package
// Shared widths, register codes and the command flag type of the 3x3 local
// binary pattern block.
// ---------------------------------------------------------------------------
package lbp_pkg;

   localparam int PIX_W        = 8;
   localparam int CODE_W       = 8;
   localparam int ROW_W        = 13;
   localparam int OUT_ROW_W    = 12;
   localparam int OUT_COL_W    = 11;
   localparam int RSP_DATA_W   = 32;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   // Classification of one item, made by the front and carried out by the back.
   typedef struct packed {
      logic drain;      // item belongs to the zero row below the image
      logic first_col;  // column zero: window is cleared before the shift
      logic end_row;    // last column: a zero column follows
      logic mid_ok;     // a row lies above the incoming one
      logic top_ok;     // two rows lie above the incoming one
   } lbp_flags_type;

endpackage

@@ rtl/lbp_ram.sv @@
// ---------------------------------------------------------------------------
// LBP generic RAM
// Single write port, single read port with registered read data.
// ---------------------------------------------------------------------------
module lbp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lbp_cmd_queue.sv @@
// ---------------------------------------------------------------------------
// LBP command queue
// Small register FIFO that decouples the front classifier from the back.
// ---------------------------------------------------------------------------
module lbp_cmd_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != (PW+1)'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ rtl/lbp_front.sv @@
// ---------------------------------------------------------------------------
// LBP front
// Holds the size registers and the raster position, drops items that do not
// fit the current phase and classifies the others for the back.
// ---------------------------------------------------------------------------
module lbp_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lbp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                in_valid,
   input  logic                                in_ready,
   input  logic                                in_action,
   input  logic [lbp_pkg::PIX_W-1:0]           in_pixel,
   output logic                                cmd_valid,
   output lbp_pkg::lbp_flags_type              cmd_flags,
   output logic [lbp_pkg::ROW_W-1:0]           cmd_row,
   output logic [$clog2(MAX_WIDTH)-1:0]        cmd_col,
   output logic [lbp_pkg::PIX_W-1:0]           cmd_pixel
);

   import lbp_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
   localparam int HCW  = ($clog2(MAX_HEIGHT + 1) > ROW_W + 1) ?
                         $clog2(MAX_HEIGHT + 1) : ROW_W + 1;

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [CW-1:0]           col_ff, col_in;
   logic                    drain_ff, drain_in;
   logic                    take;
   logic                    row_end, frame_end;
   logic [CMPW-1:0]         col_inc;
   logic [HCW-1:0]          row_inc;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_REG_W-1:0];
         endcase
      end
   end

   // Items whose kind does not match the phase (pixel or drain row) are dropped.
   assign take = in_valid && in_ready && (in_action == drain_ff);

   always_comb begin
      col_inc   = CMPW'(col_ff) + CMPW'(1);
      row_inc   = HCW'(row_ff) + HCW'(1);
      row_end   = (col_inc >= CMPW'(width_ff)) || (col_ff == CW'(MAX_WIDTH - 1));
      frame_end = (row_inc >= HCW'(height_ff)) || (row_inc >= HCW'(MAX_HEIGHT));
      row_in    = row_ff;
      col_in    = col_ff;
      drain_in  = drain_ff;
      if (take) begin
         if (row_end) begin
            col_in = '0;
            if (drain_ff) begin
               row_in   = '0;
               drain_in = 1'b0;
            end else begin
               row_in = row_ff + 1'b1;
               if (frame_end) begin
                  drain_in = 1'b1;
               end
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         drain_ff <= 1'b0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         drain_ff <= drain_in;
      end
   end

   always_comb begin
      cmd_valid           = take;
      cmd_flags.drain     = drain_ff;
      cmd_flags.first_col = (col_ff == '0);
      cmd_flags.end_row   = row_end;
      cmd_flags.mid_ok    = (row_ff != '0);
      cmd_flags.top_ok    = (row_ff[ROW_W-1:1] != '0);
      cmd_row             = row_ff;
      cmd_col             = col_ff;
      cmd_pixel           = in_pixel;
   end

endmodule

@@ rtl/lbp_back.sv @@
// ---------------------------------------------------------------------------
// LBP back
// Reads and updates the two-row line store, shifts the 3x3 window one column a
// cycle when not stalled and registers the codes toward the result channel.
// ---------------------------------------------------------------------------
module lbp_back #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   output logic                                cmd_ready,
   input  lbp_pkg::lbp_flags_type              cmd_flags,
   input  logic [lbp_pkg::ROW_W-1:0]           cmd_row,
   input  logic [$clog2(MAX_WIDTH)-1:0]        cmd_col,
   input  logic [lbp_pkg::PIX_W-1:0]           cmd_pixel,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lbp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast
);

   import lbp_pkg::*;

   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int OCW     = (CW > OUT_COL_W) ? CW : OUT_COL_W;
   localparam int ENTRY_W = 2 * PIX_W;

   // Store stage: one item whose line store entry has been read.
   logic                 p1_valid_ff;
   logic                 p1_phase_ff;
   lbp_flags_type        p1_flags_ff;
   logic [ROW_W-1:0]     p1_row_ff;
   logic [CW-1:0]        p1_col_ff;
   logic [PIX_W-1:0]     p1_pixel_ff;
   logic                 p1_fwd_ff;
   logic [ENTRY_W-1:0]   p1_fwd_data_ff;

   // Window stage.
   logic [PIX_W-1:0]     win_ff [3][3];
   logic [PIX_W-1:0]     new_col [3];
   logic                 win_valid_ff, win_valid_in;
   logic [OUT_ROW_W-1:0] win_row_ff;
   logic [OUT_COL_W-1:0] win_col_ff;
   logic                 win_last_ff;

   // Output register.
   logic                 rsp_valid_ff;
   logic [CODE_W-1:0]    rsp_code_ff;
   logic [OUT_ROW_W-1:0] rsp_row_ff;
   logic [OUT_COL_W-1:0] rsp_col_ff;
   logic                 rsp_last_ff;

   logic                 rsp_load, can_shift, shift_item, shift_zero;
   logic                 p1_done, pop, fwd_hit;
   logic [ENTRY_W-1:0]   ram_rdata, store_rd, ram_wdata;
   logic                 ram_we;
   logic [ROW_W-1:0]     row_m1;
   logic [OCW-1:0]       col_ext, col_m1_ext;
   logic [CODE_W-1:0]    code;
   logic [PIX_W-1:0]     ctr;

   always_comb begin
      rsp_load   = win_valid_ff && (!rsp_valid_ff || rsp_tready);
      can_shift  = !win_valid_ff || rsp_load;
      shift_item = p1_valid_ff && !p1_phase_ff && can_shift;
      shift_zero = p1_valid_ff && p1_phase_ff && can_shift;
      p1_done    = shift_zero || (shift_item && !p1_flags_ff.end_row);
      cmd_ready  = !p1_valid_ff || p1_done;
      pop        = cmd_valid && cmd_ready;

      // A write to the address being read in the same cycle is forwarded.
      store_rd   = p1_fwd_ff ? p1_fwd_data_ff : ram_rdata;
      ram_we     = shift_item && !p1_flags_ff.drain;
      ram_wdata  = {store_rd[PIX_W-1:0], p1_pixel_ff};
      fwd_hit    = ram_we && (p1_col_ff == cmd_col);

      new_col[0] = p1_flags_ff.top_ok ? store_rd[ENTRY_W-1:PIX_W] : '0;
      new_col[1] = p1_flags_ff.mid_ok ? store_rd[PIX_W-1:0] : '0;
      new_col[2] = p1_flags_ff.drain ? '0 : p1_pixel_ff;

      row_m1     = p1_row_ff - 1'b1;
      col_ext    = OCW'(p1_col_ff);
      col_m1_ext = OCW'(p1_col_ff - 1'b1);
   end

   lbp_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(p1_col_ff),
      .wr_data(ram_wdata),
      .rd_en  (pop),
      .rd_addr(cmd_col),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p1_phase_ff <= 1'b0;
      end else if (pop) begin
         p1_valid_ff <= 1'b1;
         p1_phase_ff <= 1'b0;
      end else if (p1_done) begin
         p1_valid_ff <= 1'b0;
      end else if (shift_item) begin
         p1_phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         p1_flags_ff    <= cmd_flags;
         p1_row_ff      <= cmd_row;
         p1_col_ff      <= cmd_col;
         p1_pixel_ff    <= cmd_pixel;
         p1_fwd_ff      <= fwd_hit;
         p1_fwd_data_ff <= ram_wdata;
      end
   end

   always_comb begin
      win_valid_in = win_valid_ff;
      if (shift_item) begin
         win_valid_in = p1_flags_ff.mid_ok && !p1_flags_ff.first_col;
      end else if (shift_zero) begin
         win_valid_in = p1_flags_ff.mid_ok;
      end else if (rsp_load) begin
         win_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= 1'b0;
      end else begin
         win_valid_ff <= win_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_item) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= p1_flags_ff.first_col ? '0 : win_ff[i][1];
            win_ff[i][1] <= p1_flags_ff.first_col ? '0 : win_ff[i][2];
            win_ff[i][2] <= new_col[i];
         end
         win_row_ff  <= row_m1[OUT_ROW_W-1:0];
         win_col_ff  <= col_m1_ext[OUT_COL_W-1:0];
         win_last_ff <= 1'b0;
      end else if (shift_zero) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
            win_ff[i][2] <= '0;
         end
         win_row_ff  <= row_m1[OUT_ROW_W-1:0];
         win_col_ff  <= col_ext[OUT_COL_W-1:0];
         win_last_ff <= p1_flags_ff.drain;
      end
   end

   // Bit 7 is the top-left neighbor, then clockwise down to bit 0 on the left.
   always_comb begin
      ctr     = win_ff[1][1];
      code[7] = win_ff[0][0] > ctr;
      code[6] = win_ff[0][1] > ctr;
      code[5] = win_ff[0][2] > ctr;
      code[4] = win_ff[1][2] > ctr;
      code[3] = win_ff[2][2] > ctr;
      code[2] = win_ff[2][1] > ctr;
      code[1] = win_ff[2][0] > ctr;
      code[0] = win_ff[1][0] > ctr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_code_ff <= code;
         rsp_row_ff  <= win_row_ff;
         rsp_col_ff  <= win_col_ff;
         rsp_last_ff <= win_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_col_ff, rsp_row_ff, rsp_code_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ rtl/lbp_3x3_raster_operator.sv @@
// ---------------------------------------------------------------------------
// LBP 3x3 raster operator
// Local binary pattern of each pixel of a raster-ordered grey image stream.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transaction: tdata is the pixel, tuser is the
//   kind (0 pixel, 1 drain tick). After the last pixel row of a frame, one
//   row of drain ticks supplies the zero row below the image; pixels sent
//   during that row, and drain ticks sent outside it, are dropped.
//   rsp_* carries one code per transaction with its row and column; tlast
//   marks the code of the bottom-right pixel of the frame.
//   csr_* writes image_width (index 0) and image_height (index 1); write them
//   only while no transaction is in flight.
//   The code of pixel (r, c) follows the item at (r+1, c+1), or the last item
//   of row r+1 for the right column, and reaches rsp_tvalid through the
//   command queue, store stage, window and output register; the right
//   column waits in the store stage for the zero-column shift. One item
//   is taken per cycle while the queue has room; the last item of each
//   row gives two codes and holds the window shifter for that extra
//   shift; a four-entry command queue absorbs it and short stalls.
//   When rsp_tready is low the output register and window hold, the queue
//   fills and req_tready drops. Reset clears the position, the phase and all
//   valid flags and sets the sizes to 640 x 480; the line store needs no
//   clearing since rows above the image never use its data.
// ---------------------------------------------------------------------------
module lbp_3x3_raster_operator #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] pixel
   input  logic                               req_tuser,   // [0] action
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] code, [19:8] out_row, [30:20] out_col, [31] zero
   output logic [lbp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,   // last_of_frame
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lbp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import lbp_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int FLW = $bits(lbp_flags_type);
   localparam int QW  = FLW + ROW_W + CW + PIX_W;

   logic               q_push, q_in_ready;
   lbp_flags_type      f_flags;
   logic [ROW_W-1:0]   f_row;
   logic [CW-1:0]      f_col;
   logic [PIX_W-1:0]   f_pixel;
   logic [QW-1:0]      q_in_data, q_out_data;
   logic               q_out_valid, q_out_ready;
   lbp_flags_type      b_flags;

   assign req_tready = q_in_ready;

   lbp_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .in_valid (req_tvalid),
      .in_ready (q_in_ready),
      .in_action(req_tuser),
      .in_pixel (req_tdata),
      .cmd_valid(q_push),
      .cmd_flags(f_flags),
      .cmd_row  (f_row),
      .cmd_col  (f_col),
      .cmd_pixel(f_pixel)
   );

   assign q_in_data = {f_flags, f_row, f_col, f_pixel};

   lbp_cmd_queue #(
      .WIDTH(QW),
      .DEPTH(4)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_push),
      .in_ready (q_in_ready),
      .in_data  (q_in_data),
      .out_valid(q_out_valid),
      .out_ready(q_out_ready),
      .out_data (q_out_data)
   );

   assign b_flags = lbp_flags_type'(q_out_data[QW-1 -: FLW]);

   lbp_back #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_out_valid),
      .cmd_ready (q_out_ready),
      .cmd_flags (b_flags),
      .cmd_row   (q_out_data[ROW_W+CW+PIX_W-1 -: ROW_W]),
      .cmd_col   (q_out_data[CW+PIX_W-1 -: CW]),
      .cmd_pixel (q_out_data[PIX_W-1:0]),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // The front only queues work for an accepted transaction.
   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (req_tvalid && req_tready))
      else $error("command queued without an accepted transaction");

   // The last code of a frame has zero right and bottom neighbors.
   a_last_code_border: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[5:1] == 5'd0))
      else $error("last code of frame sets a right or bottom neighbor bit");

   // No result is offered in the cycle after reset.
   a_reset_clears_output: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

@@ dv/tb.sv @@
// ---------------------------------------------------------------------------
// LBP 3x3 raster operator testbench
// Streams pixel frames and drain rows through the block and predicts every
// code, with its row, column and end-of-frame flag, from a local copy of the
// window, the two line stores and the raster position. It covers a directed
// frame, a zero-size frame and random frames with size changes between and
// inside frames, under three send and receive stall mixes.
// ---------------------------------------------------------------------------
module tb;
   import lbp_pkg::*;

   localparam int MAX_W         = 2048;
   localparam int MAX_H         = 4096;
   localparam int LATENCY_PAUSE = 8;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_ITEMS  = 600;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef struct {
      logic       kind;
      logic [7:0] pixel;
   } stream_item_type;

   typedef struct {
      logic [7:0]  code;
      logic [11:0] row;
      logic [10:0] col;
      logic        last;
   } lbp_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata  = '0;
   logic                    req_tuser  = KIND_PIXEL;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index  = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   lbp_3x3_raster_operator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   stream_item_type pending_items[$];
   lbp_result_type  expected_codes[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors        = 0;
   int items_taken   = 0;
   int codes_checked = 0;
   int frames_seen   = 0;
   int csr_writes    = 0;
   int random_items  = 0;
   int cycles        = 0;

   // Local image of the block: line stores with a written flag per entry,
   // the 3x3 window (row 0 top, column 0 left), position and sizes.
   logic [7:0]              line_prev  [MAX_W];
   logic [7:0]              line_older [MAX_W];
   bit                      prev_known [MAX_W];
   bit                      older_known[MAX_W];
   logic [7:0]              win [3][3];
   int                      row_cnt  = 0;
   int                      col_cnt  = 0;
   bit                      in_drain = 1'b0;
   logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
   logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;

   function automatic int clamp_width(input logic [WIDTH_REG_W-1:0] wv);
      if (wv == 0) return 1;
      if (wv > MAX_W) return MAX_W;
      return int'(wv);
   endfunction

   function automatic int clamp_height(input logic [HEIGHT_REG_W-1:0] hv);
      if (hv == 0) return 1;
      if (hv > MAX_H) return MAX_H;
      return int'(hv);
   endfunction

   function automatic logic [7:0] window_code();
      logic [7:0] ctr;
      ctr = win[1][1];
      return {win[0][0] > ctr, win[0][1] > ctr, win[0][2] > ctr, win[1][2] > ctr,
              win[2][2] > ctr, win[2][1] > ctr, win[2][0] > ctr, win[1][0] > ctr};
   endfunction

   task automatic shift_window(input logic [7:0] t, input logic [7:0] m,
                               input logic [7:0] b);
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = t;
      win[1][2] = m;
      win[2][2] = b;
   endtask

   task automatic post_code(input int r, input int c, input bit last);
      lbp_result_type res;
      res.code = window_code();
      res.row  = r[11:0];
      res.col  = c[10:0];
      res.last = last;
      expected_codes.push_back(res);
   endtask

   task automatic predict_item(input logic kind, input logic [7:0] pix);
      int w, h, r, c;
      logic [7:0] top, mid, bot;
      if ((kind == KIND_DRAIN) != in_drain) return;
      w = clamp_width(width_reg);
      h = clamp_height(height_reg);
      r = row_cnt;
      c = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
      top = (r >= 2) ? line_older[c] : 8'd0;
      mid = (r >= 1) ? line_prev[c] : 8'd0;
      bot = in_drain ? 8'd0 : pix;
      if (!in_drain) begin
         line_older[c]  = line_prev[c];
         older_known[c] = prev_known[c];
         line_prev[c]   = pix;
         prev_known[c]  = 1'b1;
      end
      // A new row starts from an empty window: the left border is zero.
      if (c == 0) begin
         for (int i = 0; i < 3; i++) begin
            win[i][1] = 8'd0;
            win[i][2] = 8'd0;
         end
      end
      shift_window(top, mid, bot);
      if (r >= 1 && c >= 1) post_code(r - 1, c - 1, 1'b0);
      if (c + 1 >= w) begin
         shift_window(8'd0, 8'd0, 8'd0);
         if (r >= 1) post_code(r - 1, c, in_drain);
         col_cnt = 0;
         if (in_drain) begin
            row_cnt  = 0;
            in_drain = 1'b0;
         end else begin
            row_cnt = (r + 1) & 32'h1FFF;
            if (r + 1 >= h) in_drain = 1'b1;
         end
      end else begin
         col_cnt = c + 1;
      end
   endtask

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
         errors++;
      end
   endtask

   // Request driver: a held item stays on the bus until it is taken.
   always @(posedge clock) begin : drive_req
      stream_item_type item;
      if (!req_tvalid || req_tready) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= item.kind;
            req_tdata  <= item.pixel;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Prediction comes before the check so that the order of blocks in a
   // time step does not matter.
   always @(posedge clock) begin : watch
      lbp_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH) width_reg = csr_wdata[WIDTH_REG_W-1:0];
            else if (csr_index == CSR_IMAGE_HEIGHT) height_reg = csr_wdata;
            csr_writes++;
         end
         if (req_tvalid && req_tready) begin
            predict_item(req_tuser, req_tdata);
            items_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_codes.size() == 0) begin
               $display("%0t: unexpected transaction: expected none, actual %08h last %0b",
                        $time, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               want = expected_codes.pop_front();
               check_field("code", 32'(want.code), 32'(rsp_tdata[7:0]));
               check_field("out_row", 32'(want.row), 32'(rsp_tdata[19:8]));
               check_field("out_col", 32'(want.col), 32'(rsp_tdata[30:20]));
               check_field("last_of_frame", 32'(want.last), 32'(rsp_tlast));
               codes_checked++;
               if (rsp_tlast) frames_seen++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d codes outstanding", $time, expected_codes.size());
         $display("tb: errors");
         $finish;
      end
   end

   task automatic push_item(input logic kind, input logic [7:0] pix);
      stream_item_type item;
      item.kind  = kind;
      item.pixel = pix;
      pending_items.push_back(item);
   endtask

   function automatic logic [7:0] rand_pixel();
      case ($urandom_range(3))
         0, 1: return 8'($urandom);
         2: return 8'($urandom_range(100, 103));
         default: return $urandom_range(1) ? 8'd255 : 8'd0;
      endcase
   endfunction

   // Queues well-formed items from the current position, with some items of
   // the wrong kind mixed in; optionally stops where the frame ends.
   task automatic gen_chunk(input int n, input int noise_pct, input bit stop_at_end);
      int gw, gh, gr, gc, done;
      bit gd;
      gw = clamp_width(width_reg);
      gh = clamp_height(height_reg);
      gr = row_cnt;
      gc = col_cnt;
      gd = in_drain;
      done = 0;
      while (done < n) begin
         if ($urandom_range(99) < noise_pct) begin
            push_item(gd ? KIND_PIXEL : KIND_DRAIN, rand_pixel());
         end else begin
            push_item(gd ? KIND_DRAIN : KIND_PIXEL, gd ? 8'($urandom) : rand_pixel());
            done++;
            random_items++;
            if (gc + 1 >= gw) begin
               gc = 0;
               if (gd) begin
                  gr = 0;
                  gd = 1'b0;
                  if (stop_at_end) break;
               end else begin
                  gr++;
                  if (gr >= gh) gd = 1'b1;
               end
            end else begin
               gc++;
            end
         end
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_codes.size() != 0);
      // Ignored items may still be inside the block.
      repeat (LATENCY_PAUSE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Growing the width inside a frame would read store entries that were
   // never written, so a change there is only made when every column of the
   // new width already holds data in both stores.
   function automatic bit width_change_safe(input logic [WIDTH_REG_W-1:0] wv);
      if (row_cnt == 0 && col_cnt == 0 && !in_drain) return 1'b1;
      for (int c = 0; c < clamp_width(wv); c++)
         if (!prev_known[c] || !older_known[c]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic set_stalls(input int phase);
      case (phase)
         0: begin send_idle_pct = 17; recv_idle_pct = 84; end
         1: begin send_idle_pct = 84; recv_idle_pct = 17; end
         default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
   endtask

   task automatic random_config();
      logic [CSR_DATA_W-1:0] nw, nh;
      case ($urandom_range(9))
         0: nw = '0;
         1, 2: nw = 13'($urandom_range(13, 40));
         default: nw = 13'($urandom_range(1, 12));
      endcase
      nw[12] = 1'($urandom_range(1));
      nh = ($urandom_range(7) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
      if ($urandom_range(2) != 0 && width_change_safe(nw[WIDTH_REG_W-1:0]))
         write_csr(CSR_IMAGE_WIDTH, nw);
      if ($urandom_range(2) != 0) write_csr(CSR_IMAGE_HEIGHT, nh);
   endtask

   initial begin : stimulus
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) win[i][j] = 8'd0;
      set_stalls(0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed 3x3 frame with both pixel extremes and ties, plus a drain
      // tick outside the drain row and a pixel inside it, both dropped.
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, 13'd3);
      write_csr(CSR_IMAGE_HEIGHT, 13'd3);
      push_item(KIND_DRAIN, 8'd9);
      push_item(KIND_PIXEL, 8'd0);
      push_item(KIND_PIXEL, 8'd255);
      push_item(KIND_PIXEL, 8'd0);
      push_item(KIND_PIXEL, 8'd255);
      push_item(KIND_PIXEL, 8'd50);
      push_item(KIND_PIXEL, 8'd50);
      push_item(KIND_PIXEL, 8'd49);
      push_item(KIND_PIXEL, 8'd51);
      push_item(KIND_PIXEL, 8'd255);
      push_item(KIND_DRAIN, 8'd0);
      push_item(KIND_PIXEL, 8'd200);
      push_item(KIND_DRAIN, 8'd255);
      push_item(KIND_DRAIN, 8'd0);

      // Zero sizes act as a single-pixel frame: the drain tick gives its
      // only code.
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, 13'd0);
      write_csr(CSR_IMAGE_HEIGHT, 13'd0);
      push_item(KIND_PIXEL, 8'd77);
      push_item(KIND_DRAIN, 8'd77);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, 13'd5);
      write_csr(CSR_IMAGE_HEIGHT, 13'd4);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         set_stalls(random_items * 3 / RANDOM_ITEMS);
         gen_chunk($urandom_range(1, 60), 8, 1'b0);
         wait_idle();
         if ($urandom_range(2) != 0) random_config();
      end

      // Finish the frame in progress without stalls.
      set_stalls(2);
      if (row_cnt != 0 || col_cnt != 0 || in_drain) begin
         gen_chunk(32'h7FFF_FFFF, 0, 1'b1);
         wait_idle();
      end

      if (expected_codes.size() != 0) begin
         $display("%0t: %0d codes never arrived", $time, expected_codes.size());
         errors++;
      end
      $display("summary: %0d items taken, %0d codes checked, %0d frames completed,",
               items_taken, codes_checked, frames_seen);
      $display("summary: %0d register writes, %0d mismatches", csr_writes, errors);
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
